@@ sv/xtea_block_cipher_assert.svh @@
// ----------------------------------------------------------------------------
// XTEA block cipher assertion macros
// Concurrent checks clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTH
`define XTEA_ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (expr)) else $error(msg);
`define XTEA_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (expr)) else $error(msg);
`else
`define XTEA_ASSERT_IMPLY(label, cond, expr, msg)
`define XTEA_ASSERT_NEXT(label, cond, expr, msg)
`endif

`endif

@@ sv/xtea_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA package
// Shared types, register indexes and round constants of the XTEA engine.
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam int WORD_W      = 32;
    localparam int KEY_WORDS   = 4;
    localparam int CFG_INDEX_W = 4;
    localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_array_t;

    typedef struct packed {
        logic              dec;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } xtea_item_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_WORD0 = 4'd0,
        REG_KEY_WORD1 = 4'd1,
        REG_KEY_WORD2 = 4'd2,
        REG_KEY_WORD3 = 4'd3
    } cfg_reg_t;

    function automatic logic [WORD_W-1:0] sum_at(input int unsigned count);
        logic [63:0] prod;
        prod = 64'(count) * 64'(DELTA);
        return prod[WORD_W-1:0];
    endfunction

endpackage

@@ sv/xtea_block_cipher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher
// Electronic-codebook XTEA engine, 64-bit block, 128-bit key.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per 64-bit block; s_tuser selects decrypt (1)
//   or encrypt (0). m_ channel: one transaction per block, in input order.
//   cfg channel: writes key words 0..3 at indexes 0..3; other indexes are
//   dropped. cfg_ready is always high. Write the key only while no block is
//   in flight.
// Pipeline: one registered half-round stage per Feistel half-round, followed
//   by the output register.
// Throughput: one block per cycle while m_tready is high.
// Reset: clears the pipeline, output and skid valid bits and sets the key
//   words to zero.
// Stall: when m_tready is low the output register holds; one more block is
//   caught in the skid register, after which s_tready drops and the whole
//   pipeline holds until the output is taken.
// ----------------------------------------------------------------------------
module xtea_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,   // block_low, block_high
    input  logic                                s_tuser,   // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [63:0]                         m_tdata,   // out_low, out_high
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [xtea_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [xtea_pkg::WORD_W-1:0]         cfg_data
);
    import xtea_pkg::*;

    `include "xtea_block_cipher_assert.svh"

    localparam int STAGES = 2 * ROUNDS;

    key_array_t        key_reg;
    logic              pipe_en;
    logic [STAGES:0]   stage_valid;
    xtea_item_t        stage_item [0:STAGES];

    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_data_reg, out_data_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [63:0]       skid_data_reg, skid_data_next;
    logic [63:0]       last_data;
    logic              last_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_KEY_WORD0: key_reg[0] <= cfg_data;
                REG_KEY_WORD1: key_reg[1] <= cfg_data;
                REG_KEY_WORD2: key_reg[2] <= cfg_data;
                REG_KEY_WORD3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pipe_en  = ~skid_valid_reg;
    assign s_tready = pipe_en;

    assign stage_valid[0]   = s_tvalid;
    assign stage_item[0].dec = s_tuser;
    assign stage_item[0].v0  = s_tdata[31:0];
    assign stage_item[0].v1  = s_tdata[63:32];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        xtea_half_round #(
            .ROUNDS (ROUNDS),
            .HALF   (i)
        ) u_half (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (stage_valid[i]),
            .in_item   (stage_item[i]),
            .key       (key_reg),
            .out_valid (stage_valid[i+1]),
            .out_item  (stage_item[i+1])
        );
    end

    assign last_data = {stage_item[STAGES].v1, stage_item[STAGES].v0};
    assign last_fire = pipe_en && stage_valid[STAGES];

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (m_tvalid && m_tready) begin
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (last_fire) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = 1'b1;
                out_data_next  = last_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = last_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `XTEA_ASSERT_IMPLY(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid without output")
    `XTEA_ASSERT_IMPLY(a_skid_blocks_in, skid_valid_reg, !s_tready, "input open on full skid")
    `XTEA_ASSERT_NEXT(a_hold_on_stall, !pipe_en, $stable(stage_valid[STAGES:1]), "stall moved")
    `XTEA_ASSERT_NEXT(a_skid_drains, !pipe_en && m_tready, pipe_en && m_tvalid, "skid stuck")

endmodule

@@ sv/xtea_half_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One Feistel half-round for either direction, registered, with valid.
// ----------------------------------------------------------------------------
module xtea_half_round #(
    parameter int ROUNDS = 32,
    parameter int HALF   = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  xtea_pkg::xtea_item_t in_item,
    input  xtea_pkg::key_array_t key,
    output logic                out_valid,
    output xtea_pkg::xtea_item_t out_item
);
    import xtea_pkg::*;

    localparam int          RIDX    = HALF / 2;
    localparam logic        ODD     = 1'(HALF % 2);
    localparam int unsigned ENC_CNT = (HALF % 2 == 1) ? RIDX + 1 : RIDX;
    localparam int unsigned DEC_CNT = (HALF % 2 == 1) ? ROUNDS - RIDX - 1 : ROUNDS - RIDX;
    localparam logic [WORD_W-1:0] ENC_SUM = sum_at(ENC_CNT);
    localparam logic [WORD_W-1:0] DEC_SUM = sum_at(DEC_CNT);

    logic              valid_reg;
    xtea_item_t        item_reg;
    logic              to_v0;
    logic [WORD_W-1:0] sum;
    logic [1:0]        kidx;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] dst;
    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] dst_new;
    xtea_item_t        item_next;

    always_comb begin
        to_v0   = ~(ODD ^ in_item.dec);
        sum     = in_item.dec ? DEC_SUM : ENC_SUM;
        kidx    = to_v0 ? sum[1:0] : sum[12:11];
        src     = to_v0 ? in_item.v1 : in_item.v0;
        dst     = to_v0 ? in_item.v0 : in_item.v1;
        mixed   = (((src << 4) ^ (src >> 5)) + src) ^ (sum + key[kidx]);
        dst_new = in_item.dec ? dst - mixed : dst + mixed;
        item_next     = in_item;
        if (to_v0) begin
            item_next.v0 = dst_new;
        end else begin
            item_next.v1 = dst_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher testbench
// Sends 64-bit blocks for encryption and decryption under a series of keys
// and compares every output block against a cycle-free software model of
// the cipher. The run starts with a short fixed set of blocks, then random
// blocks and encrypt/decrypt round trips. Both stream sides idle at random,
// and a long output stall fills the pipeline so that the input backs up.
// ----------------------------------------------------------------------------
module testbench;
    import xtea_pkg::*;

    localparam int          XTEA_ROUNDS    = 32;
    localparam logic [31:0] DEC_SUM_START  = 32'hC6EF_3720;
    localparam int          LATENCY        = 2 * XTEA_ROUNDS + 1;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_BLOCKS   = 125;
    localparam int          LONG_HOLD      = 400;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = CFG_INDEX_W'(KEY_WORDS);
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_INDEX   = '1;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [63:0]            m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [WORD_W-1:0]      cfg_data;

    key_array_t  key_shadow;
    logic [63:0] cipher_q[$];
    int          err_count;
    int          enc_count;
    int          dec_count;
    int          trip_count;
    int          key_count;
    int          stall_cycles;
    int          cycle_count;
    int          burst_left;
    bit          long_hold_req;

    localparam xtea_item_t DIRECTED_BLOCKS [12] = '{
        {1'b0, 32'h0000_0000, 32'h0000_0000},
        {1'b1, 32'h0000_0000, 32'h0000_0000},
        {1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {1'b0, 32'h0000_0000, 32'hFFFF_FFFF},
        {1'b1, 32'hFFFF_FFFF, 32'h0000_0000},
        {1'b0, 32'h8000_0000, 32'h0000_0001},
        {1'b1, 32'h0000_0001, 32'h8000_0000},
        {1'b0, 32'h5555_5555, 32'hAAAA_AAAA},
        {1'b1, 32'hAAAA_AAAA, 32'h5555_5555},
        {1'b0, 32'h0123_4567, 32'h89AB_CDEF},
        {1'b1, 32'hFEDC_BA98, 32'h7654_3210}
    };

    xtea_block_cipher dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [31:0] round_mix(input logic [31:0] v, input logic [31:0] sum,
                                              input logic [31:0] kw);
        return (((v << 4) ^ (v >> 5)) + v) ^ (sum + kw);
    endfunction

    // returns {block_high, block_low}
    function automatic logic [63:0] xtea_cipher(input logic dec, input logic [31:0] v0_in,
                                                input logic [31:0] v1_in, input key_array_t key);
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] sum;
        v0 = v0_in;
        v1 = v1_in;
        if (!dec) begin
            sum = '0;
            repeat (XTEA_ROUNDS) begin
                v0  += round_mix(v1, sum, key[sum[1:0]]);
                sum += DELTA;
                v1  += round_mix(v0, sum, key[sum[12:11]]);
            end
        end else begin
            sum = DEC_SUM_START;
            repeat (XTEA_ROUNDS) begin
                v1  -= round_mix(v0, sum, key[sum[12:11]]);
                sum -= DELTA;
                v0  -= round_mix(v1, sum, key[sum[1:0]]);
            end
        end
        return {v1, v0};
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return ~(32'h1 << $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_block(input logic dec, input logic [31:0] lo, input logic [31:0] hi);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= dec;
        s_tdata  <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (cipher_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_key(input key_array_t key);
        write_reg(REG_KEY_WORD2, key[2]);
        write_reg(REG_KEY_WORD0, key[0]);
        write_reg(REG_KEY_WORD3, key[3]);
        write_reg(REG_KEY_WORD1, key[1]);
        write_reg(CFG_INDEX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_INDEX)), $urandom());
        key_count++;
    endtask

    task automatic run_directed();
        foreach (DIRECTED_BLOCKS[i])
            send_block(DIRECTED_BLOCKS[i].dec, DIRECTED_BLOCKS[i].v0, DIRECTED_BLOCKS[i].v1);
        drain();
    endtask

    // receiver: ready pattern switches to a randomly chosen mode at random intervals
    initial begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       phase;
        m_tready  = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_ALWAYS:   m_tready <= 1'b1;
                    RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_tready <= (phase % 3 == 0);
                    default:     m_tready <= 1'b1;
                endcase
            end
        end
    end

    // scoreboard: predict on input transaction, check on output transaction
    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready && cfg_index < REG_FIRST_UNUSED)
                key_shadow[cfg_index[1:0]] = cfg_data;
            if (s_tvalid && !s_tready)
                stall_cycles++;
            if (s_tvalid && s_tready) begin
                cipher_q.push_back(xtea_cipher(s_tuser, s_tdata[31:0], s_tdata[63:32], key_shadow));
                if (s_tuser) dec_count++;
                else enc_count++;
            end
            if (m_tvalid && m_tready) begin
                if (cipher_q.size() == 0) begin
                    if (err_count < MAX_REPORTS)
                        $display("unexpected output block %h", m_tdata);
                    err_count++;
                end else begin
                    want = cipher_q.pop_front();
                    if (m_tdata[31:0] !== want[31:0] || m_tdata[63:32] !== want[63:32]) begin
                        if (err_count < MAX_REPORTS)
                            $display("mismatch out_low exp %h got %h, out_high exp %h got %h",
                                     want[31:0], m_tdata[31:0], want[63:32], m_tdata[63:32]);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d blocks pending", cycle_count, cipher_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        key_array_t  key;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] ct;
        int          sent;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        key_shadow    = '0;
        err_count     = 0;
        enc_count     = 0;
        dec_count     = 0;
        trip_count    = 0;
        key_count     = 1;
        stall_cycles  = 0;
        cycle_count   = 0;
        burst_left    = 0;
        long_hold_req = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        set_key('1);
        run_directed();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       key = '0;
                1:       key = {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
                2:       key = '1;
                default: key = {pick_word(), pick_word(), pick_word(), pick_word()};
            endcase
            set_key(key);
            if (p == 1 || p == 5)
                long_hold_req = 1'b1;
            sent = 0;
            while (sent < PHASE_BLOCKS) begin
                lo = pick_word();
                hi = pick_word();
                if ($urandom_range(0, 3) == 0) begin
                    send_block(1'b0, lo, hi);
                    ct = xtea_cipher(1'b0, lo, hi, key_shadow);
                    send_block(1'b1, ct[31:0], ct[63:32]);
                    trip_count++;
                    sent += 2;
                end else begin
                    send_block(1'($urandom_range(0, 1)), lo, hi);
                    sent++;
                end
            end
            drain();
        end

        repeat (LATENCY + 8) @(posedge aclk);
        if (cipher_q.size() != 0) begin
            $display("%0d blocks never came out", cipher_q.size());
            err_count++;
        end
        $display("covered %0d blocks (%0d encrypt, %0d decrypt, %0d round trips) under %0d keys",
                 enc_count + dec_count, enc_count, dec_count, trip_count, key_count);
        $display("input held off %0d cycles by output backpressure; %0d errors",
                 stall_cycles, err_count);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
